[design/btpc_pkg.sv]
// shared types and constants for the barometric compensation block
// depends on nothing; used by baro_temp_pressure_compensation
package btpc_pkg;

    // pressure phases that follow one temperature phase
    localparam int unsigned PRESSURE_PER_TEMPERATURE_DEF = 3;

    // configuration register indexes
    localparam logic [2:0] REG_OVERSAMPLING = 3'd0;
    localparam logic [2:0] REG_COEFF_A_FIRST = 3'd1;
    localparam logic [2:0] REG_COEFF_A_SECOND = 3'd2;
    localparam logic [2:0] REG_COEFF_B_PAIR = 3'd3;
    localparam logic [2:0] REG_COEFF_M_PAIR = 3'd4;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W = 48;
    localparam logic [1:0] OSS_RESET = 2'd1;

    // compensation constants of the scheme
    localparam logic signed [63:0] B6_OFFSET = 64'sd4000;
    localparam logic signed [63:0] X3_BIAS = 64'sd32768;
    localparam logic [63:0] B7_SCALE = 64'd50000;
    localparam logic signed [63:0] P_COEF_SQ = 64'sd3038;
    localparam logic signed [63:0] P_COEF_LIN = -64'sd7357;
    localparam logic signed [63:0] P_COEF_OFS = 64'sd3791;
    localparam logic signed [63:0] P_MAX = 64'sd131071;

    // divider magnitude width; every dividend and divisor fits in it
    localparam int unsigned DIV_STEPS = 34;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_T_MUL,
        ST_T_DIV,
        ST_B5,
        ST_SQ,
        ST_X1A,
        ST_X3A,
        ST_X1B,
        ST_X3B,
        ST_B4,
        ST_B7,
        ST_QDIV,
        ST_PSQ,
        ST_PT1,
        ST_PFIN,
        ST_OUT
    } state_t;

    // saturate a wide signed value to 16 bits
    function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
        logic signed [15:0] r;
        if (v > 64'sd32767)
            r = 16'sh7fff;
        else if (v < -64'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

endpackage

[design/baro_temp_pressure_compensation.sv]
// barometric temperature and pressure compensation, bit-serial datapath
// one item at a time: a new request is accepted only after the result is loaded
// into the output register, which waits while the previous result is held
// reset: asynchronous active low; phase counter to temperature phase, raw temp zero
module baro_temp_pressure_compensation #(
    parameter int unsigned PRESSURE_PER_TEMPERATURE = btpc_pkg::PRESSURE_PER_TEMPERATURE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [btpc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [btpc_pkg::CFG_DATA_W-1:0]  cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [23:0] adc_word
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [15:0] temperature_deci_c, [32:16] pressure_pa, zero pad
    output logic [1:0]  m_tuser    // [0] pressure_valid, [1] divide_error
);

    localparam int unsigned PHASE_W = $clog2(PRESSURE_PER_TEMPERATURE + 1);
    localparam int unsigned DIV_CNT_W = $clog2(btpc_pkg::DIV_STEPS + 1);
    localparam int unsigned DW = btpc_pkg::DIV_STEPS;

    // configuration registers
    logic [1:0]  oss_reg;
    logic [47:0] coeff_a_first_reg;
    logic [47:0] coeff_a_second_reg;
    logic [31:0] coeff_b_pair_reg;
    logic [31:0] coeff_m_pair_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oss_reg <= btpc_pkg::OSS_RESET;
            coeff_a_first_reg <= '0;
            coeff_a_second_reg <= '0;
            coeff_b_pair_reg <= '0;
            coeff_m_pair_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                btpc_pkg::REG_OVERSAMPLING:   oss_reg <= cfg_data[1:0];
                btpc_pkg::REG_COEFF_A_FIRST:  coeff_a_first_reg <= cfg_data;
                btpc_pkg::REG_COEFF_A_SECOND: coeff_a_second_reg <= cfg_data;
                btpc_pkg::REG_COEFF_B_PAIR:   coeff_b_pair_reg <= cfg_data[31:0];
                btpc_pkg::REG_COEFF_M_PAIR:   coeff_m_pair_reg <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // calibration words, extended to the datapath width
    logic signed [63:0] ac1, ac2, ac3, b1, b2, mc, md;
    logic [63:0] ac4, ac5, ac6;
    assign ac1 = {{48{coeff_a_first_reg[47]}}, coeff_a_first_reg[47:32]};
    assign ac2 = {{48{coeff_a_first_reg[31]}}, coeff_a_first_reg[31:16]};
    assign ac3 = {{48{coeff_a_first_reg[15]}}, coeff_a_first_reg[15:0]};
    assign ac4 = {48'd0, coeff_a_second_reg[47:32]};
    assign ac5 = {48'd0, coeff_a_second_reg[31:16]};
    assign ac6 = {48'd0, coeff_a_second_reg[15:0]};
    assign b1 = {{48{coeff_b_pair_reg[31]}}, coeff_b_pair_reg[31:16]};
    assign b2 = {{48{coeff_b_pair_reg[15]}}, coeff_b_pair_reg[15:0]};
    assign mc = {{48{coeff_m_pair_reg[31]}}, coeff_m_pair_reg[31:16]};
    assign md = {{48{coeff_m_pair_reg[15]}}, coeff_m_pair_reg[15:0]};

    // control and working registers
    btpc_pkg::state_t state_reg, state_next;
    logic [PHASE_W-1:0] phase_count_reg;
    logic [15:0] stored_raw_temp_reg;
    logic [23:0] adc_reg;
    logic        temp_phase_reg;
    logic        err_reg;
    logic        dbl_reg;
    logic signed [63:0] x1_reg, b5_reg, b6_reg, sq_reg, t1_reg, b3_reg, p_reg;
    logic [16:0] b4_reg;
    logic signed [15:0] temp_reg;
    logic [16:0] pres_reg;
    logic        pv_reg;

    // output register
    logic        out_valid_reg;
    logic [15:0] out_temp_reg;
    logic [16:0] out_pres_reg;
    logic        out_pv_reg;
    logic        out_err_reg;

    // serial multiplier: one multiplier bit per cycle, stops when it runs out
    logic        mul_start;
    logic [63:0] mul_a_in, mul_b_in;
    logic [63:0] mul_a_reg, mul_b_reg, mul_acc_reg;
    logic        mul_busy_reg;
    logic signed [63:0] prod;
    assign prod = $signed(mul_acc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mul_busy_reg <= 1'b0;
        else if (mul_start)
            mul_busy_reg <= 1'b1;
        else if (mul_busy_reg && (mul_b_reg == '0))
            mul_busy_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (mul_start)
        begin
            // keep the serial operand non-negative
            mul_a_reg <= mul_b_in[63] ? (64'd0 - mul_a_in) : mul_a_in;
            mul_b_reg <= mul_b_in[63] ? (64'd0 - mul_b_in) : mul_b_in;
            mul_acc_reg <= '0;
        end
        else if (mul_busy_reg && (mul_b_reg != '0))
        begin
            mul_acc_reg <= mul_acc_reg + (mul_b_reg[0] ? mul_a_reg : 64'd0);
            mul_a_reg <= {mul_a_reg[62:0], 1'b0};
            mul_b_reg <= {1'b0, mul_b_reg[63:1]};
        end
    end

    // serial restoring divider on magnitudes, truncating toward zero
    logic        div_start;
    logic signed [63:0] div_n_in, div_d_in;
    logic [63:0] div_n_abs, div_d_abs;
    logic [DW-1:0] div_num_reg, div_den_reg, div_rem_reg;
    logic        div_neg_reg;
    logic        div_busy_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [DW:0] div_shift;
    logic        div_fit;
    logic signed [63:0] div_q;

    assign div_n_abs = div_n_in[63] ? $unsigned(-div_n_in) : $unsigned(div_n_in);
    assign div_d_abs = div_d_in[63] ? $unsigned(-div_d_in) : $unsigned(div_d_in);
    assign div_shift = {div_rem_reg, div_num_reg[DW-1]};
    assign div_fit = (div_shift >= {1'b0, div_den_reg});
    assign div_q = div_neg_reg ? -$signed({{(64-DW){1'b0}}, div_num_reg})
                               : $signed({{(64-DW){1'b0}}, div_num_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
            div_cnt_reg <= '0;
        end
        else if (div_start)
        begin
            div_busy_reg <= 1'b1;
            div_cnt_reg <= DIV_CNT_W'(btpc_pkg::DIV_STEPS);
        end
        else if (div_busy_reg)
        begin
            div_cnt_reg <= div_cnt_reg - 1'b1;
            if (div_cnt_reg == DIV_CNT_W'(1))
                div_busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            div_neg_reg <= div_n_in[63] ^ div_d_in[63];
            div_num_reg <= div_n_abs[DW-1:0];
            div_den_reg <= div_d_abs[DW-1:0];
            div_rem_reg <= '0;
        end
        else if (div_busy_reg)
        begin
            div_rem_reg <= div_fit ? DW'(div_shift - {1'b0, div_den_reg}) : div_shift[DW-1:0];
            div_num_reg <= {div_num_reg[DW-2:0], div_fit};
        end
    end

    // raw pressure word for the current oversampling setting
    function automatic logic [23:0] s_tdata_hold(input logic [23:0] adc, input logic [1:0] oss);
        logic [23:0] r;
        r = adc >> (4'd8 - {2'b00, oss});
        return r;
    endfunction

    // combinational helpers of the compensation steps
    logic        in_accept;
    logic        in_temp_phase;
    logic [15:0] ut_in;
    logic signed [63:0] x1_t, den_t, b6_c, x3_a, b3_c, x3_b, x3_bias;
    logic signed [63:0] up_c, b7_diff, p_div, p_fin;
    logic [31:0] b7_c;

    assign in_accept = s_tvalid && s_tready;
    assign in_temp_phase = (phase_count_reg == '0);
    assign ut_in = in_temp_phase ? s_tdata[23:8] : stored_raw_temp_reg;
    assign x1_t = prod >>> 15;
    assign den_t = x1_t + md;
    assign b6_c = b5_reg - btpc_pkg::B6_OFFSET;
    assign x3_a = t1_reg + (prod >>> 11);
    assign b3_c = ((((ac1 <<< 2) + x3_a) <<< oss_reg) + 64'sd2) >>> 2;
    assign x3_b = (t1_reg + (prod >>> 16) + 64'sd2) >>> 2;
    assign x3_bias = x3_b + btpc_pkg::X3_BIAS;
    assign up_c = $signed({40'd0, s_tdata_hold(adc_reg, oss_reg)});
    assign b7_diff = up_c - b3_reg;
    assign b7_c = prod[31:0];
    assign p_div = dbl_reg ? (div_q <<< 1) : div_q;
    assign p_fin = p_reg + ((t1_reg + (prod >>> 16) + btpc_pkg::P_COEF_OFS) >>> 4);

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= btpc_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state and unit requests
    always_comb
    begin
        state_next = state_reg;
        mul_start = 1'b0;
        mul_a_in = '0;
        mul_b_in = '0;
        div_start = 1'b0;
        div_n_in = '0;
        div_d_in = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            btpc_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    mul_start = 1'b1;
                    mul_a_in = $unsigned($signed({48'd0, ut_in}) - $signed(ac6));
                    mul_b_in = ac5;
                    state_next = btpc_pkg::ST_T_MUL;
                end
            end
            btpc_pkg::ST_T_MUL:
            begin
                if (!mul_busy_reg)
                begin
                    if (den_t == '0)
                        state_next = btpc_pkg::ST_B5;
                    else
                    begin
                        div_start = 1'b1;
                        div_n_in = mc <<< 11;
                        div_d_in = den_t;
                        state_next = btpc_pkg::ST_T_DIV;
                    end
                end
            end
            btpc_pkg::ST_T_DIV:
            begin
                if (!div_busy_reg)
                    state_next = btpc_pkg::ST_B5;
            end
            btpc_pkg::ST_B5:
            begin
                if (temp_phase_reg)
                    state_next = btpc_pkg::ST_OUT;
                else
                begin
                    mul_start = 1'b1;
                    mul_a_in = $unsigned(b6_c);
                    mul_b_in = $unsigned(b6_c);
                    state_next = btpc_pkg::ST_SQ;
                end
            end
            btpc_pkg::ST_SQ:
            begin
                if (!mul_busy_reg)
                begin
                    mul_start = 1'b1;
                    mul_a_in = $unsigned(prod >>> 12);
                    mul_b_in = $unsigned(b2);
                    state_next = btpc_pkg::ST_X1A;
                end
            end
            btpc_pkg::ST_X1A:
            begin
                if (!mul_busy_reg)
                begin
                    mul_start = 1'b1;
                    mul_a_in = $unsigned(b6_reg);
                    mul_b_in = $unsigned(ac2);
                    state_next = btpc_pkg::ST_X3A;
                end
            end
            btpc_pkg::ST_X3A:
            begin
                if (!mul_busy_reg)
                begin
                    mul_start = 1'b1;
                    mul_a_in = $unsigned(b6_reg);
                    mul_b_in = $unsigned(ac3);
                    state_next = btpc_pkg::ST_X1B;
                end
            end
            btpc_pkg::ST_X1B:
            begin
                if (!mul_busy_reg)
                begin
                    mul_start = 1'b1;
                    mul_a_in = $unsigned(sq_reg);
                    mul_b_in = $unsigned(b1);
                    state_next = btpc_pkg::ST_X3B;
                end
            end
            btpc_pkg::ST_X3B:
            begin
                if (!mul_busy_reg)
                begin
                    mul_start = 1'b1;
                    mul_a_in = {32'd0, x3_bias[31:0]};
                    mul_b_in = ac4;
                    state_next = btpc_pkg::ST_B4;
                end
            end
            btpc_pkg::ST_B4:
            begin
                if (!mul_busy_reg)
                begin
                    mul_start = 1'b1;
                    mul_a_in = {32'd0, b7_diff[31:0]};
                    mul_b_in = btpc_pkg::B7_SCALE >> oss_reg;
                    state_next = btpc_pkg::ST_B7;
                end
            end
            btpc_pkg::ST_B7:
            begin
                if (!mul_busy_reg)
                begin
                    if (b4_reg == '0)
                    begin
                        // zero divisor: pressure quotient is zero
                        mul_start = 1'b1;
                        state_next = btpc_pkg::ST_PSQ;
                    end
                    else
                    begin
                        div_start = 1'b1;
                        div_n_in = b7_c[31] ? $signed({32'd0, b7_c})
                                            : $signed({31'd0, b7_c, 1'b0});
                        div_d_in = $signed({47'd0, b4_reg});
                        state_next = btpc_pkg::ST_QDIV;
                    end
                end
            end
            btpc_pkg::ST_QDIV:
            begin
                if (!div_busy_reg)
                begin
                    mul_start = 1'b1;
                    mul_a_in = $unsigned(p_div >>> 8);
                    mul_b_in = $unsigned(p_div >>> 8);
                    state_next = btpc_pkg::ST_PSQ;
                end
            end
            btpc_pkg::ST_PSQ:
            begin
                if (!mul_busy_reg)
                begin
                    mul_start = 1'b1;
                    mul_a_in = mul_acc_reg;
                    mul_b_in = $unsigned(btpc_pkg::P_COEF_SQ);
                    state_next = btpc_pkg::ST_PT1;
                end
            end
            btpc_pkg::ST_PT1:
            begin
                if (!mul_busy_reg)
                begin
                    mul_start = 1'b1;
                    mul_a_in = $unsigned(p_reg);
                    mul_b_in = $unsigned(btpc_pkg::P_COEF_LIN);
                    state_next = btpc_pkg::ST_PFIN;
                end
            end
            btpc_pkg::ST_PFIN:
            begin
                if (!mul_busy_reg)
                    state_next = btpc_pkg::ST_OUT;
            end
            btpc_pkg::ST_OUT:
            begin
                if (!out_valid_reg || m_tready)
                    state_next = btpc_pkg::ST_IDLE;
            end
            default: state_next = btpc_pkg::ST_IDLE;
        endcase
    end

    // phase counter and stored raw temperature
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_count_reg <= '0;
            stored_raw_temp_reg <= '0;
        end
        else if (in_accept)
        begin
            if (in_temp_phase)
                stored_raw_temp_reg <= s_tdata[23:8];
            if (phase_count_reg == PHASE_W'(PRESSURE_PER_TEMPERATURE))
                phase_count_reg <= '0;
            else
                phase_count_reg <= phase_count_reg + 1'b1;
        end
    end

    // working values captured as each step finishes
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            btpc_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    adc_reg <= s_tdata;
                    temp_phase_reg <= in_temp_phase;
                    err_reg <= 1'b0;
                end
            end
            btpc_pkg::ST_T_MUL:
            begin
                if (!mul_busy_reg)
                begin
                    x1_reg <= x1_t;
                    b5_reg <= x1_t;
                    if (den_t == '0)
                        err_reg <= 1'b1;
                end
            end
            btpc_pkg::ST_T_DIV:
            begin
                if (!div_busy_reg)
                    b5_reg <= x1_reg + div_q;
            end
            btpc_pkg::ST_B5:
            begin
                temp_reg <= btpc_pkg::sat16((b5_reg + 64'sd8) >>> 4);
                b6_reg <= b6_c;
                pres_reg <= '0;
                pv_reg <= 1'b0;
            end
            btpc_pkg::ST_SQ:
            begin
                if (!mul_busy_reg)
                    sq_reg <= prod >>> 12;
            end
            btpc_pkg::ST_X1A:
            begin
                if (!mul_busy_reg)
                    t1_reg <= prod >>> 11;
            end
            btpc_pkg::ST_X3A:
            begin
                if (!mul_busy_reg)
                    b3_reg <= b3_c;
            end
            btpc_pkg::ST_X1B:
            begin
                if (!mul_busy_reg)
                    t1_reg <= prod >>> 13;
            end
            btpc_pkg::ST_B4:
            begin
                if (!mul_busy_reg)
                    b4_reg <= prod[31:15];
            end
            btpc_pkg::ST_B7:
            begin
                if (!mul_busy_reg)
                begin
                    dbl_reg <= b7_c[31];
                    if (b4_reg == '0)
                    begin
                        err_reg <= 1'b1;
                        p_reg <= '0;
                    end
                end
            end
            btpc_pkg::ST_QDIV:
            begin
                if (!div_busy_reg)
                    p_reg <= p_div;
            end
            btpc_pkg::ST_PT1:
            begin
                if (!mul_busy_reg)
                    t1_reg <= prod >>> 16;
            end
            btpc_pkg::ST_PFIN:
            begin
                if (!mul_busy_reg)
                begin
                    pv_reg <= 1'b1;
                    if (p_fin < 64'sd0)
                        pres_reg <= '0;
                    else if (p_fin > btpc_pkg::P_MAX)
                        pres_reg <= '1;
                    else
                        pres_reg <= p_fin[16:0];
                end
            end
            default: ;
        endcase
    end

    // output register, loaded once the previous result is taken or the register is empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if ((state_reg == btpc_pkg::ST_OUT) && (!out_valid_reg || m_tready))
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == btpc_pkg::ST_OUT) && (!out_valid_reg || m_tready))
        begin
            out_temp_reg <= temp_reg;
            out_pres_reg <= pres_reg;
            out_pv_reg <= pv_reg;
            out_err_reg <= err_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {7'd0, out_pres_reg, out_temp_reg};
    assign m_tuser = {out_err_reg, out_pv_reg};

    // the two serial units never run at once
    assert property (@(posedge clk) disable iff (!rst_n)
        !(mul_busy_reg && div_busy_reg))
        else $error("multiplier and divider busy together");

    // a temperature report carries no pressure
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[32:16] == '0))
        else $error("pressure set on a temperature report");

    // phase counter stays within its cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_count_reg <= PHASE_W'(PRESSURE_PER_TEMPERATURE))
        else $error("phase counter out of range");

    // an accepted request always starts the temperature multiply
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == btpc_pkg::ST_T_MUL) && mul_busy_reg)
        else $error("accepted request did not start");

endmodule
